@@ hdl/spg_pkg.sv @@
// shared types, constants and codes for the scanline span generator
// no dependencies; imported by every module of the block
package spg_pkg;

   localparam int SCREEN_W_DEF     = 320;
   localparam int SCREEN_H_DEF     = 200;
   localparam int MAX_VERTICES_DEF = 64;

   localparam int COORD_W = 11;
   localparam int DIFF_W  = 12;
   localparam int POS_W   = 32;
   localparam int ROWS_W  = 12;
   localparam int ROW_W   = 8;
   localparam int COL_W   = 9;
   localparam int OP_W    = 2;
   localparam int COLOR_W = 8;
   localparam int PAGE_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [COLOR_W-1:0] COLOR_OR8  = 8'h10;
   localparam logic [COLOR_W-1:0] COLOR_COPY = 8'h11;

   localparam logic [OP_W-1:0] OP_SOLID = 2'd0;
   localparam logic [OP_W-1:0] OP_OR8   = 2'd1;
   localparam logic [OP_W-1:0] OP_COPY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR  = 1'd1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // vertex memory read address selects
   localparam logic [2:0] RD_FIRST = 3'd0;
   localparam logic [2:0] RD_LAST  = 3'd1;
   localparam logic [2:0] RD_J     = 3'd2;
   localparam logic [2:0] RD_J1    = 3'd3;
   localparam logic [2:0] RD_I     = 3'd4;
   localparam logic [2:0] RD_I1    = 3'd5;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vtx_type;

   typedef struct packed {
      logic       accept;
      logic       do_load;
      logic       do_advance;
      logic [2:0] rd_sel;
      logic       cap_en;
      logic [1:0] cap_slot;
      logic       do_start;
      logic       div_start;
      logic       div_side;
      logic       step_load_l;
      logic       step_load_r;
      logic       do_pair;
      logic       np_finish;
      logic       rsp_load;
   } spg_cmd_type;

   typedef struct packed {
      logic is_advance;
      logic start_ok;
      logic busy;
      logic row_off;
      logic row_next_off;
      logic np_more;
      logic div_done;
   } spg_sts_type;

endpackage

@@ hdl/spg_divider.sv @@
// bit-serial signed divider for edge slopes: (dx * 65536) / dy, truncating
// one quotient bit per cycle; depends on spg_pkg
module spg_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [spg_pkg::DIFF_W-1:0] dx,
   input  logic signed [spg_pkg::DIFF_W-1:0] dy,
   output logic                              done,
   output logic [spg_pkg::POS_W-1:0]         quot
);
   import spg_pkg::*;

   localparam int MAG_W = DIFF_W - 1;
   localparam int DVD_W = MAG_W + 16;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;

   logic [DIFF_W-1:0] dx_abs, dy_abs;
   logic [MAG_W:0]    trial;
   logic              ge;
   logic [POS_W-1:0]  mag;

   always_comb begin
      dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      mag    = POS_W'(quo_ff);
      quot   = neg_ff ? POS_W'(-mag) : mag;
      done   = done_ff;

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = {dx_abs[MAG_W-1:0], 16'h0000};
         rem_in = '0;
         dvs_in = (dy == '0) ? MAG_W'(1) : dy_abs[MAG_W-1:0];
         neg_in = dx[DIFF_W-1] ^ dy[DIFF_W-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? MAG_W'(trial - {1'b0, dvs_ff}) : trial[MAG_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

endmodule

@@ hdl/spg_datapath.sv @@
// datapath: vertex memory, edge walkers, span clipping, result register
// depends on spg_pkg and spg_divider
module spg_datapath #(
   parameter int SCREEN_W     = spg_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H     = spg_pkg::SCREEN_H_DEF,
   parameter int MAX_VERTICES = spg_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spg_pkg::spg_cmd_type                cmd,
   output spg_pkg::spg_sts_type                sts,
   input  logic                                csr_we,
   input  logic [spg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spg_pkg::COLOR_W-1:0]         csr_wdata,
   input  logic                                req_cmd,
   input  logic signed [spg_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [spg_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic                                req_last_vertex,
   output logic                                rsp_span_valid,
   output logic                                rsp_done_res,
   output logic [spg_pkg::ROW_W-1:0]           rsp_row,
   output logic [spg_pkg::COL_W-1:0]           rsp_x_first,
   output logic [spg_pkg::COL_W-1:0]           rsp_x_last,
   output logic [spg_pkg::OP_W-1:0]            rsp_pixel_op
);
   import spg_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic signed [16:0]       W17 = 17'(SCREEN_W);
   localparam logic signed [ROWS_W:0]   H13 = (ROWS_W + 1)'(SCREEN_H);

   // request capture
   logic                      req_cmd_ff, req_last_ff;
   vtx_type                   req_vtx_ff;

   // vertex memory
   vtx_type                   mem [MAX_VERTICES];
   vtx_type                   rdata_ff;
   logic [IDX_W-1:0]          rd_addr;

   // walker state
   logic [CNT_W-1:0]          count_ff, n_ff, pairs_ff;
   logic [IDX_W-1:0]          left_idx_ff, right_idx_ff;
   logic [POS_W-1:0]          lpos_ff, rpos_ff, lstep_ff, rstep_ff;
   logic [ROWS_W-1:0]         rows_ff;
   logic signed [ROWS_W-1:0]  row_ff;
   logic                      busy_ff;
   vtx_type                   slot_ff [4];

   // span hold and result registers
   logic                      span_valid_ff;
   logic [ROW_W-1:0]          span_row_ff;
   logic [COL_W-1:0]          span_first_ff, span_last_ff;
   logic [OP_W-1:0]           span_op_ff;
   logic                      out_valid_ff, out_done_ff;
   logic [ROW_W-1:0]          out_row_ff;
   logic [COL_W-1:0]          out_first_ff, out_last_ff;
   logic [OP_W-1:0]           out_op_ff;

   logic [COLOR_W-1:0]        fill_color_ff;
   logic [PAGE_W-1:0]         target_page_ff;

   // combinational helpers
   logic [CNT_W-1:0]          eff_cnt, n_new;
   logic                      wr_ok;
   logic signed [DIFF_W-1:0]  div_dx, div_dy, h2;
   logic                      div_done;
   logic [POS_W-1:0]          div_quot;
   logic signed [ROWS_W:0]    row13, row_next13;
   logic signed [16:0]        a17, b17, lo17, hi17, loc17, hic17, his17;
   logic                      special, span_ok;
   logic [OP_W-1:0]           op_sel;
   logic signed [COORD_W-1:0] y0, y1;

   spg_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .dx    (div_dx),
      .dy    (div_dy),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      eff_cnt = busy_ff ? '0 : count_ff;
      wr_ok   = eff_cnt < CNT_W'(MAX_VERTICES);
      n_new   = eff_cnt + CNT_W'(wr_ok);

      unique case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = IDX_W'(n_ff - 1'b1);
         RD_J:     rd_addr = left_idx_ff;
         RD_J1:    rd_addr = left_idx_ff + 1'b1;
         RD_I:     rd_addr = right_idx_ff;
         RD_I1:    rd_addr = right_idx_ff - 1'b1;
         default:  rd_addr = '0;
      endcase

      if (cmd.div_side == SIDE_LEFT) begin
         div_dx = {slot_ff[0].x[COORD_W-1], slot_ff[0].x}
                - {slot_ff[1].x[COORD_W-1], slot_ff[1].x};
         div_dy = {slot_ff[0].y[COORD_W-1], slot_ff[0].y}
                - {slot_ff[1].y[COORD_W-1], slot_ff[1].y};
      end else begin
         div_dx = {slot_ff[2].x[COORD_W-1], slot_ff[2].x}
                - {slot_ff[3].x[COORD_W-1], slot_ff[3].x};
         div_dy = {slot_ff[2].y[COORD_W-1], slot_ff[2].y}
                - {slot_ff[3].y[COORD_W-1], slot_ff[3].y};
      end
      h2 = {slot_ff[2].y[COORD_W-1], slot_ff[2].y}
         - {slot_ff[3].y[COORD_W-1], slot_ff[3].y};

      y0 = slot_ff[0].y;
      y1 = slot_ff[1].y;

      row13      = {row_ff[ROWS_W-1], row_ff};
      row_next13 = row13 + 1'b1;

      // span clipping on whole parts of the edge positions
      a17   = {lpos_ff[POS_W-1], lpos_ff[POS_W-1:16]};
      b17   = {rpos_ff[POS_W-1], rpos_ff[POS_W-1:16]};
      lo17  = (a17 > b17) ? b17 : a17;
      hi17  = (a17 > b17) ? a17 : b17;
      loc17 = (lo17 < 17'sd0) ? 17'sd0 : lo17;
      hic17 = (hi17 >= W17) ? W17 - 17'sd1 : hi17;
      special = (fill_color_ff == COLOR_OR8) || (fill_color_ff == COLOR_COPY);
      his17 = special ? hic17 - 17'sd1 : hic17;
      span_ok = busy_ff && !(row13 >= H13) && !row_ff[ROWS_W-1]
              && (lo17 < W17) && (hi17 >= 17'sd0) && (loc17 <= his17);
      priority if (fill_color_ff == COLOR_OR8) op_sel = OP_OR8;
      else if (fill_color_ff == COLOR_COPY)    op_sel = OP_COPY;
      else                                     op_sel = OP_SOLID;

      sts.is_advance   = req_cmd_ff == CMD_ADVANCE;
      sts.start_ok     = req_last_ff && (n_new >= CNT_W'(4)) && !n_new[0];
      sts.busy         = busy_ff;
      sts.row_off      = row13 >= H13;
      sts.row_next_off = row_next13 >= H13;
      sts.np_more      = (rows_ff == '0) && (pairs_ff != '0);
      sts.div_done     = div_done;

      rsp_span_valid = out_valid_ff;
      rsp_done_res   = out_done_ff;
      rsp_row        = out_row_ff;
      rsp_x_first    = out_first_ff;
      rsp_x_last     = out_last_ff;
      rsp_pixel_op   = out_op_ff;
   end

   // vertex memory
   always_ff @(posedge clock) begin
      if (cmd.do_load && wr_ok) begin
         mem[eff_cnt[IDX_W-1:0]] <= req_vtx_ff;
      end
      rdata_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         count_ff       <= '0;
         pairs_ff       <= '0;
         rows_ff        <= '0;
         fill_color_ff  <= '0;
         target_page_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TARGET_PAGE: target_page_ff <= csr_wdata[PAGE_W-1:0];
               CSR_FILL_COLOR:  fill_color_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.do_load) begin
            count_ff <= req_last_ff ? '0 : n_new;
            if (busy_ff || req_last_ff) begin
               busy_ff  <= 1'b0;
               rows_ff  <= '0;
               pairs_ff <= '0;
            end
         end
         if (cmd.do_start) begin
            busy_ff  <= 1'b1;
            pairs_ff <= (n_ff - CNT_W'(2)) >> 1;
         end
         if (cmd.do_advance && busy_ff) begin
            if (sts.row_off) begin
               busy_ff <= 1'b0;
            end else begin
               rows_ff <= rows_ff - 1'b1;
               if (sts.row_next_off) busy_ff <= 1'b0;
            end
         end
         if (cmd.do_pair) begin
            pairs_ff <= pairs_ff - 1'b1;
            if (h2 > 12'sd0) rows_ff <= ROWS_W'(h2);
         end
         if (cmd.np_finish && rows_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_cmd_ff   <= req_cmd;
         req_last_ff  <= req_last_vertex;
         req_vtx_ff.x <= req_vertex_x;
         req_vtx_ff.y <= req_vertex_y;
      end
      if (cmd.do_load) n_ff <= n_new;
      if (cmd.cap_en) slot_ff[cmd.cap_slot] <= rdata_ff;
      if (cmd.do_start) begin
         row_ff       <= (y0 < y1) ? ROWS_W'(y0) : ROWS_W'(y1);
         rpos_ff      <= {{(16 - COORD_W){slot_ff[0].x[COORD_W-1]}}, slot_ff[0].x, 16'h0000};
         lpos_ff      <= {{(16 - COORD_W){slot_ff[1].x[COORD_W-1]}}, slot_ff[1].x, 16'h0000};
         right_idx_ff <= IDX_W'(1);
         left_idx_ff  <= IDX_W'(n_ff - CNT_W'(2));
      end
      if (cmd.step_load_l) lstep_ff <= div_quot;
      if (cmd.step_load_r) rstep_ff <= div_quot;
      if (cmd.do_pair) begin
         left_idx_ff  <= left_idx_ff - 1'b1;
         right_idx_ff <= right_idx_ff + 1'b1;
         if (h2 == '0) begin
            lpos_ff <= {lpos_ff[POS_W-1:16], 16'h7fff} + lstep_ff;
            rpos_ff <= {rpos_ff[POS_W-1:16], 16'h8000} + rstep_ff;
         end else begin
            lpos_ff <= {lpos_ff[POS_W-1:16], 16'h7fff};
            rpos_ff <= {rpos_ff[POS_W-1:16], 16'h8000};
         end
      end
      if (cmd.do_advance) begin
         span_valid_ff <= span_ok;
         span_row_ff   <= span_ok ? row_ff[ROW_W-1:0] : '0;
         span_first_ff <= span_ok ? loc17[COL_W-1:0] : '0;
         span_last_ff  <= span_ok ? his17[COL_W-1:0] : '0;
         span_op_ff    <= span_ok ? op_sel : OP_SOLID;
         if (busy_ff && !sts.row_off) begin
            lpos_ff <= lpos_ff + lstep_ff;
            rpos_ff <= rpos_ff + rstep_ff;
            row_ff  <= row_ff + 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         out_valid_ff <= span_valid_ff;
         out_done_ff  <= !busy_ff;
         out_row_ff   <= span_row_ff;
         out_first_ff <= span_first_ff;
         out_last_ff  <= span_last_ff;
         out_op_ff    <= span_op_ff;
      end
   end

endmodule

@@ hdl/spg_ctrl.sv @@
// controller state machine: sequences loads, row advances, fill start,
// edge pair setup and result hand-off; depends on spg_pkg
module spg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spg_pkg::spg_cmd_type cmd,
   input  spg_pkg::spg_sts_type sts
);
   import spg_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_EXEC  = 5'd1;
   localparam logic [4:0] S_ST0   = 5'd2;
   localparam logic [4:0] S_ST1   = 5'd3;
   localparam logic [4:0] S_ST2   = 5'd4;
   localparam logic [4:0] S_ST3   = 5'd5;
   localparam logic [4:0] S_NP    = 5'd6;
   localparam logic [4:0] S_RDJ   = 5'd7;
   localparam logic [4:0] S_RDJ1  = 5'd8;
   localparam logic [4:0] S_RDI   = 5'd9;
   localparam logic [4:0] S_RDI1  = 5'd10;
   localparam logic [4:0] S_CAP   = 5'd11;
   localparam logic [4:0] S_DIVL  = 5'd12;
   localparam logic [4:0] S_WAITL = 5'd13;
   localparam logic [4:0] S_DIVR  = 5'd14;
   localparam logic [4:0] S_WAITR = 5'd15;
   localparam logic [4:0] S_PAIR  = 5'd16;
   localparam logic [4:0] S_RSP   = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       valid_ff, valid_in;

   always_comb begin
      cmd       = '0;
      cmd.rd_sel = RD_FIRST;
      state_in  = state_ff;
      pend_in   = pend_ff;
      valid_in  = valid_ff && !rsp_ready;
      req_ready = state_ff == S_IDLE;
      rsp_valid = valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!sts.is_advance) begin
               cmd.do_load = 1'b1;
               pend_in     = 1'b0;
               state_in    = sts.start_ok ? S_ST0 : S_IDLE;
            end else begin
               cmd.do_advance = 1'b1;
               pend_in        = 1'b1;
               state_in = (sts.busy && !sts.row_off && !sts.row_next_off) ? S_NP : S_RSP;
            end
         end
         S_ST0: begin
            cmd.rd_sel = RD_FIRST;
            state_in   = S_ST1;
         end
         S_ST1: begin
            cmd.rd_sel   = RD_LAST;
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd0;
            state_in     = S_ST2;
         end
         S_ST2: begin
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd1;
            state_in     = S_ST3;
         end
         S_ST3: begin
            cmd.do_start = 1'b1;
            state_in     = S_NP;
         end
         S_NP: begin
            if (sts.np_more) begin
               state_in = S_RDJ;
            end else begin
               cmd.np_finish = 1'b1;
               state_in      = pend_ff ? S_RSP : S_IDLE;
            end
         end
         S_RDJ: begin
            cmd.rd_sel = RD_J;
            state_in   = S_RDJ1;
         end
         S_RDJ1: begin
            cmd.rd_sel   = RD_J1;
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd0;
            state_in     = S_RDI;
         end
         S_RDI: begin
            cmd.rd_sel   = RD_I;
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd1;
            state_in     = S_RDI1;
         end
         S_RDI1: begin
            cmd.rd_sel   = RD_I1;
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd2;
            state_in     = S_CAP;
         end
         S_CAP: begin
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd3;
            state_in     = S_DIVL;
         end
         S_DIVL: begin
            cmd.div_start = 1'b1;
            cmd.div_side  = SIDE_LEFT;
            state_in      = S_WAITL;
         end
         S_WAITL: begin
            if (sts.div_done) begin
               cmd.step_load_l = 1'b1;
               state_in        = S_DIVR;
            end
         end
         S_DIVR: begin
            cmd.div_start = 1'b1;
            cmd.div_side  = SIDE_RIGHT;
            state_in      = S_WAITR;
         end
         S_WAITR: begin
            cmd.div_side = SIDE_RIGHT;
            if (sts.div_done) begin
               cmd.step_load_r = 1'b1;
               state_in        = S_PAIR;
            end
         end
         S_PAIR: begin
            cmd.div_side = SIDE_RIGHT;
            cmd.do_pair  = 1'b1;
            state_in     = S_NP;
         end
         S_RSP: begin
            // result register frees up when the previous transaction is taken
            if (!valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ hdl/polygon_scanline_span_generator.sv @@
// scanline polygon span generator, top level; depends on spg_pkg, spg_ctrl, spg_datapath
// a load writes its vertex; an advance of a running fill steps its edges, walks new edge
// pairs (not when idle or on the last row) and loads the result register once any held
// result is taken; no new request is taken until then; a fill start reads the first and last
// vertex; each new edge pair takes two serial 27-step slope divisions and 4 vertex reads
// synchronous active-high reset returns to idle with no vertices and no polygon
module polygon_scanline_span_generator #(
   parameter int SCREEN_W     = spg_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H     = spg_pkg::SCREEN_H_DEF,
   parameter int MAX_VERTICES = spg_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [spg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spg_pkg::COLOR_W-1:0]         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [spg_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [spg_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic                                req_last_vertex,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_span_valid,
   output logic                                rsp_done_res,
   output logic [spg_pkg::ROW_W-1:0]           rsp_row,
   output logic [spg_pkg::COL_W-1:0]           rsp_x_first,
   output logic [spg_pkg::COL_W-1:0]           rsp_x_last,
   output logic [spg_pkg::OP_W-1:0]            rsp_pixel_op
);
   import spg_pkg::*;

   spg_cmd_type cmd;
   spg_sts_type sts;

   spg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   spg_datapath #(
      .SCREEN_W     (SCREEN_W),
      .SCREEN_H     (SCREEN_H),
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .rsp_span_valid  (rsp_span_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_row         (rsp_row),
      .rsp_x_first     (rsp_x_first),
      .rsp_x_last      (rsp_x_last),
      .rsp_pixel_op    (rsp_pixel_op)
   );

endmodule

@@ sim/span_checker.sv @@
// checker for the scanline span generator: watches the load/advance and span channels,
// predicts spans from its own copy of the polygon state and counts mismatches
// depends on spg_pkg
module span_checker
   import spg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COLOR_W-1:0]        csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_cmd,
   input  logic signed [COORD_W-1:0] req_vertex_x,
   input  logic signed [COORD_W-1:0] req_vertex_y,
   input  logic                      req_last_vertex,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_span_valid,
   input  logic                      rsp_done_res,
   input  logic [ROW_W-1:0]          rsp_row,
   input  logic [COL_W-1:0]          rsp_x_first,
   input  logic [COL_W-1:0]          rsp_x_last,
   input  logic [OP_W-1:0]           rsp_pixel_op,
   output int                        fail_count,
   output int                        spans_pending
);

   localparam int SW = SCREEN_W_DEF;
   localparam int SH = SCREEN_H_DEF;
   localparam int MAXV = MAX_VERTICES_DEF;

   typedef struct packed {
      logic             span_valid;
      logic             done_res;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] x_first;
      logic [COL_W-1:0] x_last;
      logic [OP_W-1:0]  pixel_op;
   } span_type;

   span_type span_queue[$];

   logic [COLOR_W-1:0] color;
   int    vx[MAXV];
   int    vy[MAXV];
   int    nverts, lidx, ridx, pairs, rows, cur_row;
   bit    filling;
   logic [31:0] lpos, rpos, lstep, rstep;

   function automatic logic [31:0] slope(int dx, int dy);
      int d;
      d = (dy == 0) ? 1 : dy;
      return 32'(signed'(dx * 65536) / d);
   endfunction

   function automatic int whole(logic [31:0] f);
      return int'(signed'(f[31:16]));
   endfunction

   task automatic walk_pairs();
      int h2;
      while (rows == 0 && pairs > 0) begin
         h2 = vy[ridx] - vy[ridx-1];
         lstep = slope(vx[lidx] - vx[lidx+1], vy[lidx] - vy[lidx+1]);
         rstep = slope(vx[ridx] - vx[ridx-1], h2);
         lidx--;
         ridx++;
         lpos = {lpos[31:16], 16'h7fff};
         rpos = {rpos[31:16], 16'h8000};
         if (h2 == 0) begin
            lpos += lstep;
            rpos += rstep;
         end else if (h2 > 0) begin
            rows = h2;
         end
         pairs--;
      end
      if (rows == 0) filling = 0;
   endtask

   task automatic load_vertex(int x, int y, bit last);
      int n;
      if (filling) begin
         filling = 0; rows = 0; pairs = 0; nverts = 0;
      end
      if (nverts < MAXV) begin
         vx[nverts] = x; vy[nverts] = y; nverts++;
      end
      if (last) begin
         n = nverts;
         nverts = 0;
         filling = 0; rows = 0; pairs = 0;
         if (n >= 4 && n % 2 == 0) begin
            cur_row = vy[0] < vy[n-1] ? vy[0] : vy[n-1];
            rpos = 32'(vx[0]) << 16;
            lpos = 32'(vx[n-1]) << 16;
            ridx = 1;
            lidx = n - 2;
            pairs = (n - 2) / 2;
            filling = 1;
            walk_pairs();
         end
      end
   endtask

   task automatic advance_row();
      span_type s;
      int a, b, t;
      bit special;
      s = '0;
      if (filling && cur_row >= SH) filling = 0;
      if (filling) begin
         if (cur_row >= 0) begin
            a = whole(lpos);
            b = whole(rpos);
            special = (color == COLOR_OR8 || color == COLOR_COPY);
            if (a > b) begin
               t = a; a = b; b = t;
            end
            if (a < SW && b >= 0) begin
               if (a < 0) a = 0;
               if (b >= SW) b = SW - 1;
               if (special) b -= 1;
               if (a <= b) begin
                  s.span_valid = 1;
                  s.x_first = COL_W'(a);
                  s.x_last = COL_W'(b);
                  s.row = ROW_W'(cur_row);
                  s.pixel_op = color == COLOR_OR8 ? OP_OR8 :
                               (color == COLOR_COPY ? OP_COPY : OP_SOLID);
               end
            end
         end
         lpos += lstep;
         rpos += rstep;
         cur_row++;
         rows--;
         if (cur_row >= SH) filling = 0;
         else walk_pairs();
      end
      s.done_res = !filling;
      span_queue.push_back(s);
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      span_type e;
      if (reset) begin
         color = '0; nverts = 0; lidx = 0; ridx = 0; pairs = 0; rows = 0;
         cur_row = 0; filling = 0; lpos = 0; rpos = 0; lstep = 0; rstep = 0;
         span_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_we && csr_index == CSR_FILL_COLOR) color = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (span_queue.size() == 0) begin
               report("unexpected span transaction", 1, 0);
            end else begin
               e = span_queue.pop_front();
               if (rsp_span_valid !== e.span_valid)
                  report("span_valid", rsp_span_valid, e.span_valid);
               if (rsp_done_res !== e.done_res) report("done_res", rsp_done_res, e.done_res);
               if (rsp_row !== e.row) report("row", rsp_row, e.row);
               if (rsp_x_first !== e.x_first) report("x_first", rsp_x_first, e.x_first);
               if (rsp_x_last !== e.x_last) report("x_last", rsp_x_last, e.x_last);
               if (rsp_pixel_op !== e.pixel_op) report("pixel_op", rsp_pixel_op, e.pixel_op);
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_LOAD)
               load_vertex(int'(req_vertex_x), int'(req_vertex_y), req_last_vertex);
            else
               advance_row();
         end
      end
      spans_pending = span_queue.size();
   end

endmodule

@@ sim/testbench.sv @@
// top of the span generator testbench: clock, reset, register writes and polygon stimulus
// depends on spg_pkg, polygon_scanline_span_generator and span_checker
module testbench;
   import spg_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [COLOR_W-1:0]        csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_cmd;
   logic signed [COORD_W-1:0] req_vertex_x;
   logic signed [COORD_W-1:0] req_vertex_y;
   logic                      req_last_vertex;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_span_valid;
   logic                      rsp_done_res;
   logic [ROW_W-1:0]          rsp_row;
   logic [COL_W-1:0]          rsp_x_first;
   logic [COL_W-1:0]          rsp_x_last;
   logic [OP_W-1:0]           rsp_pixel_op;
   int                        fail_count;
   int                        spans_pending;
   int                        cycle;
   int                        send_idle;
   int                        recv_stall;
   int                        sent;

   polygon_scanline_span_generator dut (.*);
   span_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 2000000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // valid stays up between back-to-back transactions and drops only for idle gaps
   task automatic send(bit cmd, int x, int y, bit last);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_vertex_x <= COORD_W'(x);
      req_vertex_y <= COORD_W'(y);
      req_last_vertex <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= COLOR_W'(val);
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (spans_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // random polygon: mostly even vertex counts, sometimes 3 to 70 vertices; mostly small so many rows land on screen
   task automatic polygon(int rows_to_walk);
      int n, k, base_y;
      n = ($urandom_range(9) == 0) ? $urandom_range(3, 70) : 2 * $urandom_range(2, 4);
      base_y = ($urandom_range(3) == 0) ? $urandom_range(0, 2047) - 1024
                                        : $urandom_range(0, 230) - 20;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(3) == 0)
            send(CMD_LOAD, $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                 k == n - 1);
         else
            send(CMD_LOAD, $urandom_range(0, 400) - 40,
                 base_y + (k < n / 2 ? k : n - 1 - k) * $urandom_range(0, 12),
                 k == n - 1);
      end
      for (k = 0; k < rows_to_walk; k++)
         send(CMD_ADVANCE, $urandom, $urandom, 1'($urandom));
   endtask

   initial begin
      int ph, p;
      int colors[4] = '{0, 255, 16, 17};
      reset = 1;
      csr_we = 0; csr_index = CSR_TARGET_PAGE; csr_wdata = 0;
      req_valid = 0; req_cmd = CMD_LOAD; req_vertex_x = 0; req_vertex_y = 0;
      req_last_vertex = 0;
      cycle = 0; send_idle = 0; recv_stall = 0; sent = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(CSR_TARGET_PAGE, 3);
      write_reg(CSR_FILL_COLOR, 0);

      // directed: idle advance, rectangle, extremes, flat edges, odd and short counts
      send(CMD_ADVANCE, 0, 0, 0);
      send(CMD_LOAD, 10, 5, 0); send(CMD_LOAD, 10, 8, 0);
      send(CMD_LOAD, 50, 8, 0); send(CMD_LOAD, 50, 5, 1);
      repeat (5) send(CMD_ADVANCE, 0, 0, 0);
      send(CMD_LOAD, -1024, -3, 0); send(CMD_LOAD, -1024, 1023, 0);
      send(CMD_LOAD, 1023, 1023, 0); send(CMD_LOAD, 1023, -3, 1);
      repeat (5) send(CMD_ADVANCE, -1, -1, 1);
      send(CMD_LOAD, 0, 198, 0); send(CMD_LOAD, 5, 198, 0);
      send(CMD_LOAD, 9, 199, 0); send(CMD_LOAD, 3, 202, 1);
      repeat (3) send(CMD_ADVANCE, 0, 0, 0);
      send(CMD_LOAD, 1, 1, 0); send(CMD_LOAD, 2, 2, 0); send(CMD_LOAD, 3, 3, 1);
      send(CMD_ADVANCE, 0, 0, 0);
      send(CMD_LOAD, 1, 1, 0); send(CMD_LOAD, 2, 2, 1);
      send(CMD_ADVANCE, 0, 0, 0);
      drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 78; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 78; end
            default: begin send_idle = 11; recv_stall = 11; end
         endcase
         write_reg(CSR_TARGET_PAGE, $urandom_range(3));
         write_reg(CSR_FILL_COLOR, ph < 4 ? colors[ph] : $urandom_range(255));
         for (p = 0; p < 8; p++) polygon($urandom_range(2, 16));
         drain();
      end
      send_idle = 0; recv_stall = 0;
      drain();
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hdl/spg_pkg.sv
hdl/spg_divider.sv
hdl/spg_datapath.sv
hdl/spg_ctrl.sv
hdl/polygon_scanline_span_generator.sv
sim/span_checker.sv
sim/testbench.sv
